/* hdl/tpf_pkg.sv */
package tpf_pkg;

   localparam int MAX_PACKET_BYTES = 65535;
   localparam int PosWidth = $clog2(MAX_PACKET_BYTES + 1);

   localparam int HdrWidth = 6;
   localparam int StartWidth = HdrWidth + 1;

   localparam logic [7:0] TcpProto = 8'd6;
   localparam int ProtocolPos = 9;
   localparam int DataOffsetPos = 12;
   localparam logic [HdrWidth-1:0] MinTcpHeaderBytes = HdrWidth'(20);
   localparam int ShortSlack = 4;
   localparam logic [31:0] HttpWord = 32'h4854_5450;

   typedef enum logic [1:0] {
      REASON_NOT_TCP  = 2'd0,
      REASON_SHORT    = 2'd1,
      REASON_NO_MATCH = 2'd2,
      REASON_HTTP     = 2'd3
   } reason_type;

   typedef struct packed {
      logic       drop;
      reason_type reason;
   } verdict_type;

endpackage

/* hdl/tpf_req_if.sv */
interface tpf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       last_byte;

   modport source (output valid, output packet_byte, output last_byte, input ready);
   modport sink (input valid, input packet_byte, input last_byte, output ready);
endinterface

/* hdl/tpf_rsp_if.sv */
interface tpf_rsp_if;
   logic       valid;
   logic       ready;
   logic       drop;
   logic [1:0] reason_code;

   modport source (output valid, output drop, output reason_code, input ready);
   modport sink (input valid, input drop, input reason_code, output ready);
endinterface

/* hdl/tpf_scan.sv */
module tpf_scan (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          packet_byte,
   input  logic                last_byte,
   output tpf_pkg::verdict_type verdict
);
   import tpf_pkg::*;

   localparam logic [PosWidth-1:0] MaxPos = PosWidth'(MAX_PACKET_BYTES);

   logic [PosWidth-1:0]   pos_ff, pos_in, pos_next;
   logic [HdrWidth-1:0]   ihb_ff, ihb_in, ihb_next;
   logic [HdrWidth-1:0]   thb_ff, thb_in, thb_next;
   logic                  tcp_ff, tcp_in, tcp_next;
   logic [23:0]           recent_ff, recent_in, recent_next;
   logic                  match_ff, match_in, match_next;
   logic                  zero_ff, zero_in, zero_next;
   logic [HdrWidth-1:0]   doff_bytes;
   logic [StartWidth-1:0] start_next;
   logic [StartWidth:0]   short_limit;
   logic                  in_payload;

   function automatic logic [StartWidth-1:0] payload_start(
      input logic [HdrWidth-1:0] ihb,
      input logic [HdrWidth-1:0] thb
   );
      logic [HdrWidth-1:0] tcp_len;
      tcp_len = (thb < MinTcpHeaderBytes) ? MinTcpHeaderBytes : thb;
      return StartWidth'(ihb) + StartWidth'(tcp_len);
   endfunction

   always_comb begin
      pos_next    = pos_ff;
      ihb_next    = ihb_ff;
      thb_next    = thb_ff;
      tcp_next    = tcp_ff;
      recent_next = recent_ff;
      match_next  = match_ff;
      zero_next   = zero_ff;
      doff_bytes  = {packet_byte[7:4], 2'b00};
      in_payload  = 1'b0;
      if (pos_ff < MaxPos) begin
         if (pos_ff == '0) begin
            ihb_next = {packet_byte[3:0], 2'b00};
         end
         if (pos_ff == PosWidth'(ProtocolPos)) begin
            tcp_next = (packet_byte == TcpProto);
         end
         if (pos_ff == PosWidth'(ihb_next) + PosWidth'(DataOffsetPos)) begin
            thb_next = (doff_bytes < MinTcpHeaderBytes) ? MinTcpHeaderBytes : doff_bytes;
         end
         in_payload = (thb_next != '0) && !zero_ff &&
                      (pos_ff >= PosWidth'(payload_start(ihb_next, thb_next)));
         if (in_payload) begin
            if (packet_byte == 8'd0) begin
               zero_next = 1'b1;
            end else begin
               if ({recent_ff, packet_byte} == HttpWord) begin
                  match_next = 1'b1;
               end
               recent_next = {recent_ff[15:0], packet_byte};
            end
         end
         pos_next = pos_ff + PosWidth'(1);
      end

      // verdict is taken from the state after this byte
      start_next  = payload_start(ihb_next, thb_next);
      short_limit = (StartWidth + 1)'(start_next) + (StartWidth + 1)'(ShortSlack);
      verdict.drop = 1'b0;
      if (!tcp_next) begin
         verdict.reason = REASON_NOT_TCP;
      end else if (pos_next <= PosWidth'(short_limit)) begin
         verdict.reason = REASON_SHORT;
      end else if (match_next) begin
         verdict.reason = REASON_HTTP;
         verdict.drop   = 1'b1;
      end else begin
         verdict.reason = REASON_NO_MATCH;
      end

      // back to a clean state after every verdict
      if (last_byte) begin
         pos_in    = '0;
         ihb_in    = '0;
         thb_in    = '0;
         tcp_in    = 1'b0;
         recent_in = '0;
         match_in  = 1'b0;
         zero_in   = 1'b0;
      end else begin
         pos_in    = pos_next;
         ihb_in    = ihb_next;
         thb_in    = thb_next;
         tcp_in    = tcp_next;
         recent_in = recent_next;
         match_in  = match_next;
         zero_in   = zero_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         ihb_ff    <= '0;
         thb_ff    <= '0;
         tcp_ff    <= 1'b0;
         recent_ff <= '0;
         match_ff  <= 1'b0;
         zero_ff   <= 1'b0;
      end else if (step) begin
         pos_ff    <= pos_in;
         ihb_ff    <= ihb_in;
         thb_ff    <= thb_in;
         tcp_ff    <= tcp_in;
         recent_ff <= recent_in;
         match_ff  <= match_in;
         zero_ff   <= zero_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (thb_ff == '0) || (thb_ff >= MinTcpHeaderBytes))
      else $error("captured tcp header length below minimum");

   assert property (@(posedge clock) disable iff (reset)
      match_ff |-> tcp_ff || (pos_ff > PosWidth'(ProtocolPos)))
      else $error("match recorded before protocol byte");

   assert property (@(posedge clock) disable iff (reset)
      zero_ff |-> (thb_ff != '0))
      else $error("payload scan stopped before the tcp header was captured");

endmodule

/* hdl/tcp_payload_http_drop_filter.sv */
// a verdict is registered into the result slot when the final byte leaves the input register
// throughput: one packet byte per cycle; every byte passes once through the scan logic
// between the input register and the state/result registers; only a final byte waits,
// and only while the previous verdict has not been taken
// reset: synchronous, active high; clears the byte count, header capture, match state
// and both valid flags, so the first byte after reset starts a new packet
module tcp_payload_http_drop_filter (
   input logic      clock,
   input logic      reset,
   tpf_req_if.sink  req_if,
   tpf_rsp_if.source rsp_if
);
   import tpf_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type rsp_verdict_ff;
   verdict_type verdict;
   logic        advance;

   // a non-final byte never needs the result slot
   assign advance = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_if.ready) begin
         in_valid_in = req_if.valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   tpf_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .packet_byte (in_byte_ff),
      .last_byte   (in_last_ff),
      .verdict     (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.packet_byte;
         in_last_ff <= req_if.last_byte;
      end
      if (advance && in_last_ff) begin
         rsp_verdict_ff <= verdict;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.drop        = rsp_verdict_ff.drop;
   assign rsp_if.reason_code = rsp_verdict_ff.reason;

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_last_ff))
      else $error("verdict raised without a final byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_verdict_ff.drop == (rsp_verdict_ff.reason == REASON_HTTP)))
      else $error("drop flag disagrees with reason");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("held request lost from input register");

   assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("verdict would overwrite a pending result");

endmodule

/* tb/tcp_payload_http_drop_filter_tb.sv */
module tcp_payload_http_drop_filter_tb;
   import tpf_pkg::*;

   typedef logic [7:0] byte_list_type[$];

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } link_byte_type;

   logic clock;
   logic reset;

   tpf_req_if req_if ();
   tpf_rsp_if rsp_if ();

   tcp_payload_http_drop_filter u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // bytes waiting to be offered and verdicts still owed by the block
   link_byte_type link_bytes[$];
   verdict_type   verdicts_due[$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests;
   int hold_served;
   int hold_left;

   int mismatches;
   int bytes_accepted;
   int verdicts_checked;
   int reason_hits[4];

   link_byte_type next_byte;
   verdict_type   seen_verdict;

   // filter state as the block should hold it
   logic [PosWidth-1:0] pkt_pos;
   logic [HdrWidth-1:0] ip_hdr_len;
   logic [HdrWidth-1:0] tcp_hdr_len;
   logic                proto_is_tcp;
   logic [23:0]         tail_bytes;
   logic                http_seen;
   logic                scan_stopped;

   function automatic int payload_offset();
      return int'(ip_hdr_len) +
             ((tcp_hdr_len < MinTcpHeaderBytes) ? int'(MinTcpHeaderBytes) : int'(tcp_hdr_len));
   endfunction

   function automatic void clear_filter();
      pkt_pos      = '0;
      ip_hdr_len   = '0;
      tcp_hdr_len  = '0;
      proto_is_tcp = 1'b0;
      tail_bytes   = '0;
      http_seen    = 1'b0;
      scan_stopped = 1'b0;
   endfunction

   function automatic void filter_byte(input logic [7:0] b, input logic last);
      verdict_type v;
      if (int'(pkt_pos) < MAX_PACKET_BYTES) begin
         if (pkt_pos == '0)
            ip_hdr_len = {b[3:0], 2'b00};
         if (int'(pkt_pos) == ProtocolPos)
            proto_is_tcp = (b == TcpProto);
         if (int'(pkt_pos) == int'(ip_hdr_len) + DataOffsetPos)
            tcp_hdr_len = (b[7:4] < 4'd5) ? MinTcpHeaderBytes : {b[7:4], 2'b00};
         if (tcp_hdr_len != '0 && int'(pkt_pos) >= payload_offset() && !scan_stopped) begin
            if (b == 8'h00) begin
               scan_stopped = 1'b1;
            end else begin
               if ({tail_bytes, b} == HttpWord)
                  http_seen = 1'b1;
               tail_bytes = {tail_bytes[15:0], b};
            end
         end
         pkt_pos = pkt_pos + PosWidth'(1);
      end
      if (last) begin
         v.drop = 1'b0;
         if (!proto_is_tcp) begin
            v.reason = REASON_NOT_TCP;
         end else if (int'(pkt_pos) <= payload_offset() + ShortSlack) begin
            v.reason = REASON_SHORT;
         end else if (http_seen) begin
            v.reason = REASON_HTTP;
            v.drop   = 1'b1;
         end else begin
            v.reason = REASON_NO_MATCH;
         end
         verdicts_due.push_back(v);
         clear_filter();
      end
   endfunction

   function automatic byte_list_type text(input string s);
      byte_list_type q;
      for (int i = 0; i < s.len(); i++)
         q.push_back(s[i]);
      return q;
   endfunction

   function automatic byte_list_type tcp_header(input logic [3:0] ihl, input logic [7:0] proto,
                                                input logic [3:0] doff);
      byte_list_type hdr;
      int            ip_len;
      int            tcp_len;
      ip_len  = int'(ihl) * 4;
      tcp_len = (doff < 4'd5) ? 20 : int'(doff) * 4;
      for (int i = 0; i < ip_len + tcp_len; i++)
         hdr.push_back(8'($urandom_range(255)));
      hdr[0]           = {4'h4, ihl};
      hdr[ProtocolPos] = proto;
      hdr[ip_len + DataOffsetPos] = {doff, 4'($urandom_range(15))};
      return hdr;
   endfunction

   // payload biased towards the letters of the pattern, with the odd zero byte
   function automatic byte_list_type random_payload(input int len);
      byte_list_type pay;
      byte_list_type word;
      int            r;
      int            at;
      word = text("HTTP");
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(99);
         if (r < 45)
            pay.push_back(word[$urandom_range(3)]);
         else if (r < 48)
            pay.push_back(8'h00);
         else
            pay.push_back(8'($urandom_range(255)));
      end
      if (len >= 4 && $urandom_range(2) == 0) begin
         at = $urandom_range(len - 4);
         for (int i = 0; i < 4; i++)
            pay[at + i] = word[i];
      end
      return pay;
   endfunction

   function automatic byte_list_type random_packet();
      byte_list_type pkt;
      int            r;
      int            cut;
      logic [3:0]    ihl;
      logic [7:0]    proto;
      logic [3:0]    doff;
      r = $urandom_range(99);
      if (r < 10) begin
         // line noise of random length, one to 60 bytes
         for (int i = 0; i < $urandom_range(60, 1); i++)
            pkt.push_back(8'($urandom_range(255)));
      end else begin
         ihl   = ($urandom_range(99) < 60) ? 4'd5 : 4'($urandom_range(15));
         proto = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : TcpProto;
         doff  = ($urandom_range(99) < 60) ? 4'd5 : 4'($urandom_range(15));
         pkt   = {tcp_header(ihl, proto, doff), random_payload($urandom_range(24))};
         if ($urandom_range(9) == 0) begin
            cut = $urandom_range(pkt.size(), 1);
            pkt = pkt[0:cut-1];
         end
      end
      return pkt;
   endfunction

   function automatic void send_packet(input byte_list_type pkt);
      link_byte_type lb;
      foreach (pkt[i]) begin
         lb.data = pkt[i];
         lb.last = (i == pkt.size() - 1);
         link_bytes.push_back(lb);
      end
   endfunction

   function automatic void send_random_packets(input int byte_budget, input int min_packets);
      byte_list_type pkt;
      int            n_bytes;
      int            n_pkts;
      n_bytes = 0;
      n_pkts  = 0;
      while (n_bytes < byte_budget || n_pkts < min_packets) begin
         pkt = random_packet();
         send_packet(pkt);
         n_bytes += pkt.size();
         n_pkts++;
      end
   endfunction

   function automatic void send_directed();
      byte_list_type pkt;
      // packet over before the protocol byte
      pkt = {8'h45, 8'h00, 8'h00, 8'h00, 8'h00};
      send_packet(pkt);
      pkt = {8'hFF};
      send_packet(pkt);
      send_packet({tcp_header(4'd5, 8'd17, 4'd5), text("HTTP!")});
      send_packet({tcp_header(4'd5, 8'hFF, 4'd5), text("xHTTPx")});
      // tcp, but the packet ends ahead of the data offset byte
      pkt = tcp_header(4'd5, TcpProto, 4'd5);
      send_packet(pkt[0:24]);
      send_packet(tcp_header(4'd5, TcpProto, 4'd5));
      send_packet({tcp_header(4'd5, TcpProto, 4'd5), text("HTTP")});
      send_packet({tcp_header(4'd5, TcpProto, 4'd5), text("HTTPx")});
      send_packet({tcp_header(4'd5, TcpProto, 4'd5), text("xHTTP")});
      send_packet({tcp_header(4'd5, TcpProto, 4'd5), text("HHTTP")});
      send_packet({tcp_header(4'd5, TcpProto, 4'd5), text("ab"), 8'h00, text("HTTP")});
      send_packet({tcp_header(4'd5, TcpProto, 4'd5), text("HTT"), 8'h00, text("PHTTP")});
      send_packet({tcp_header(4'd5, TcpProto, 4'd5), text("HTTP"), 8'h00, text("z")});
      // undersized data offset counts as a plain 20 byte header
      send_packet({tcp_header(4'd5, TcpProto, 4'd0), text("zHTTP")});
      send_packet({tcp_header(4'd5, TcpProto, 4'd4), text("zzzHTTP")});
      // pattern split across the end of the tcp options must not match
      pkt = tcp_header(4'd15, TcpProto, 4'd15);
      pkt[pkt.size() - 2] = 8'h48;
      pkt[pkt.size() - 1] = 8'h54;
      send_packet({pkt, text("TPabc")});
      send_packet({tcp_header(4'd0, TcpProto, 4'd5), text("HTTPs")});
      send_packet({tcp_header(4'd5, TcpProto, 4'd15), text("..HTTP..")});
      send_packet({tcp_header(4'd5, TcpProto, 4'd5),
                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_packet({tcp_header(4'd5, TcpProto, 4'd5), 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55});
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      while (link_bytes.size() != 0 || req_if.valid || verdicts_due.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid       <= 1'b0;
         req_if.packet_byte <= '0;
         req_if.last_byte   <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            filter_byte(req_if.packet_byte, req_if.last_byte);
            bytes_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (link_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_byte = link_bytes.pop_front();
               req_if.valid       <= 1'b1;
               req_if.packet_byte <= next_byte.data;
               req_if.last_byte   <= next_byte.last;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // long receive hold-off, counted in cycles
   always @(posedge clock) begin
      if (reset) begin
         hold_left   <= 0;
         hold_served <= 0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= 400;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // verdict monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (verdicts_due.size() == 0) begin
               $error("verdict with none owed: drop=%0b reason_code=%0d",
                      rsp_if.drop, rsp_if.reason_code);
               mismatches++;
            end else begin
               seen_verdict = verdicts_due.pop_front();
               if (rsp_if.drop !== seen_verdict.drop) begin
                  $error("drop: expected %0b, got %0b", seen_verdict.drop, rsp_if.drop);
                  mismatches++;
               end
               if (rsp_if.reason_code !== seen_verdict.reason) begin
                  $error("reason_code: expected %0d (%s), got %0d", seen_verdict.reason,
                         seen_verdict.reason.name(), rsp_if.reason_code);
                  mismatches++;
               end
               reason_hits[seen_verdict.reason]++;
               verdicts_checked++;
            end
         end
         if (hold_served != hold_requests || hold_left != 0) begin
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.packet_byte = '0;
      req_if.last_byte   = 1'b0;
      rsp_if.ready       = 1'b0;
      send_idle_pct      = 24;
      recv_idle_pct      = 80;
      hold_requests      = 0;
      mismatches         = 0;
      bytes_accepted     = 0;
      verdicts_checked   = 0;
      reason_hits        = '{default: 0};
      clear_filter();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      send_directed();
      send_random_packets(350, 5);
      wait_drained();

      send_idle_pct = 80;
      recv_idle_pct = 24;
      send_random_packets(350, 5);
      wait_drained();

      // receiver stalls for a long while with random packets queued up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      send_random_packets(350, 5);
      wait_drained();

      $display("%0d verdicts checked over %0d packet bytes", verdicts_checked, bytes_accepted);
      $display("not tcp %0d, too short %0d, no match %0d, http dropped %0d",
               reason_hits[REASON_NOT_TCP], reason_hits[REASON_SHORT],
               reason_hits[REASON_NO_MATCH], reason_hits[REASON_HTTP]);
      if (mismatches == 0) begin
         $display("tcp_payload_http_drop_filter test passed");
      end else begin
         $display("tcp_payload_http_drop_filter test failed");
      end
      $finish;
   end

   initial begin
      #200_000;
      $display("tcp_payload_http_drop_filter test failed");
      $finish;
   end

endmodule

/* files.f */
hdl/tpf_pkg.sv
hdl/tpf_req_if.sv
hdl/tpf_rsp_if.sv
hdl/tpf_scan.sv
hdl/tcp_payload_http_drop_filter.sv
tb/tcp_payload_http_drop_filter_tb.sv
